>>> rtl/core/apq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apq_pkg: shared types and constants of the array priority queue
// Queue depth, derived widths, request and status codes, and the command and
// status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package apq_pkg;

    // queue geometry
    localparam int DEPTH = 8;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    // payload widths
    localparam int VAL_W = 32;
    localparam int PRI_W = 8;
    localparam int REQ_W = 2;
    localparam int STS_W = 2;

    // request codes
    localparam logic [REQ_W-1:0] REQ_PUSH = 2'd0;
    localparam logic [REQ_W-1:0] REQ_POP  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_PEEK = 2'd2;

    // result status codes
    typedef enum logic [STS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // controller to datapath commands
    typedef struct packed {
        logic    push;        // append request payload at the tail
        logic    scan_init;   // start a search from slot zero
        logic    shift_init;  // start a shift from the slot after the winner
        logic    rd;          // read slot at the walk address, advance it
        logic    pop_dec;     // drop one entry from the count
        logic    result;      // load the result registers
        logic    ret_best;    // result carries the winning entry
        t_status status;      // result status code
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic cnt_zero;   // queue is empty
        logic cnt_full;   // queue is full
        logic addr_last;  // walk address sits on the last stored entry
        logic best_last;  // winner is the last stored entry
    } t_dp_sts;

endpackage
`default_nettype wire

>>> rtl/core/array_priority_queue_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// array_priority_queue_core: bounded priority queue over an unsorted array
// Push appends, peek reports the best entry, pop removes it and closes the gap.
// ----------------------------------------------------------------------------
// Usage:
//   A request (type, value, priority) is taken on a rising edge with start
//   high and busy low. Every request produces exactly one result, shown for
//   a single cycle with o_done high; the receiver cannot stall it.
//   A push, a no-op, or a pop/peek on an empty queue completes with busy
//   staying low. A peek searches all n stored entries; a pop also shifts
//   every entry after the winning slot down by one when the winner is not
//   the last entry. Both walks go through the slot storage's single
//   registered read port: the search reads one slot a cycle and the shift
//   moves one slot a cycle. During a search busy stays high from the
//   accepting edge until the cycle in which o_done is high, where it is low.
//   Reset (i_rst_n low, synchronous) empties the queue and drops any
//   request in flight; slot contents are not cleared, only the count.
// ----------------------------------------------------------------------------
module array_priority_queue_core
    import apq_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic        [REQ_W-1:0] i_req_type,
    input  wire logic signed [VAL_W-1:0] i_in_value,
    input  wire logic        [PRI_W-1:0] i_in_priority,
    output logic                         o_done,
    output logic             [STS_W-1:0] o_status,
    output logic signed      [VAL_W-1:0] o_out_value,
    output logic             [PRI_W-1:0] o_out_priority,
    output logic             [IDX_W-1:0] o_out_index,
    output logic             [CNT_W-1:0] o_occupancy
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // request sequencing
    apq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req_type (i_req_type),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // storage, search and result path
    apq_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_in_value     (i_in_value),
        .i_in_priority  (i_in_priority),
        .o_done         (o_done),
        .o_status       (o_status),
        .o_out_value    (o_out_value),
        .o_out_priority (o_out_priority),
        .o_out_index    (o_out_index),
        .o_occupancy    (o_occupancy)
    );

`ifndef ASSERT_OFF
    // results only leave once the sequencer is back at rest
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result issued while busy");

    // occupancy never exceeds the depth
    a_occ_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_occupancy <= CNT_W'(DEPTH)))
        else $error("occupancy above depth");

    // full status only with a full queue
    a_full_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == ST_FULL)) |-> (o_occupancy == CNT_W'(DEPTH)))
        else $error("full status with room left");

    // empty status only with an empty queue
    a_empty_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == ST_EMPTY)) |-> (o_occupancy == '0))
        else $error("empty status with entries stored");
`endif

endmodule
`default_nettype wire

>>> rtl/core/apq_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apq_dp: array priority queue datapath
// Slot storage with one registered read port, the running best-entry search,
// the shift-down write path, the entry count and the result registers.
// ----------------------------------------------------------------------------
module apq_dp
    import apq_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire t_dp_cmd                 i_cmd,
    output t_dp_sts                      o_sts,
    input  wire logic signed [VAL_W-1:0] i_in_value,
    input  wire logic        [PRI_W-1:0] i_in_priority,
    output logic                         o_done,
    output logic             [STS_W-1:0] o_status,
    output logic signed      [VAL_W-1:0] o_out_value,
    output logic             [PRI_W-1:0] o_out_priority,
    output logic             [IDX_W-1:0] o_out_index,
    output logic             [CNT_W-1:0] o_occupancy
);

    // slot storage, undefined until written
    logic signed [VAL_W-1:0] r_slot_value    [DEPTH];
    logic        [PRI_W-1:0] r_slot_priority [DEPTH];

    logic        [CNT_W-1:0] r_count;
    logic        [CNT_W-1:0] n_count;
    logic        [IDX_W-1:0] r_addr;
    logic                    r_shift_mode;

    // registered read port
    logic                    r_rd_vld;
    logic        [IDX_W-1:0] r_rd_idx;
    logic signed [VAL_W-1:0] r_rd_val;
    logic        [PRI_W-1:0] r_rd_pri;

    // running winner
    logic        [IDX_W-1:0] r_best_idx;
    logic signed [VAL_W-1:0] r_best_val;
    logic        [PRI_W-1:0] r_best_pri;

    logic                    w_better;
    logic        [CNT_W-1:0] w_last;

    // count bookkeeping
    assign w_last = r_count - CNT_W'(1);

    always_comb begin
        n_count = r_count;
        if (i_cmd.push) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_cmd.pop_dec) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // status toward the controller
    assign o_sts.cnt_zero  = (r_count == '0);
    assign o_sts.cnt_full  = (r_count == CNT_W'(DEPTH));
    assign o_sts.addr_last = (CNT_W'(r_addr) == w_last);
    assign o_sts.best_last = (CNT_W'(r_best_idx) == w_last);

    // walk address and mode
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_init) begin
            r_addr       <= '0;
            r_shift_mode <= 1'b0;
        end else if (i_cmd.shift_init) begin
            r_addr       <= r_best_idx + IDX_W'(1);
            r_shift_mode <= 1'b1;
        end else if (i_cmd.rd) begin
            r_addr       <= r_addr + IDX_W'(1);
        end
    end

    // slot read, one address per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.rd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_addr;
        r_rd_val <= r_slot_value[r_addr];
        r_rd_pri <= r_slot_priority[r_addr];
    end

    // slot write: tail append on push, one slot down during a shift
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_slot_value[r_count[IDX_W-1:0]]    <= i_in_value;
            r_slot_priority[r_count[IDX_W-1:0]] <= i_in_priority;
        end else if (r_rd_vld && r_shift_mode) begin
            r_slot_value[r_rd_idx - IDX_W'(1)]    <= r_rd_val;
            r_slot_priority[r_rd_idx - IDX_W'(1)] <= r_rd_pri;
        end
    end

    // higher priority wins, then larger signed value, earliest on a full tie
    assign w_better = (r_rd_pri > r_best_pri) ||
                      ((r_rd_pri == r_best_pri) && (r_rd_val > r_best_val));

    always_ff @(posedge i_clk) begin
        if (r_rd_vld && !r_shift_mode && ((r_rd_idx == '0) || w_better)) begin
            r_best_idx <= r_rd_idx;
            r_best_val <= r_rd_val;
            r_best_pri <= r_rd_pri;
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= i_cmd.result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.result) begin
            o_status    <= i_cmd.status;
            o_occupancy <= n_count;
            if (i_cmd.ret_best) begin
                o_out_value    <= r_best_val;
                o_out_priority <= r_best_pri;
                o_out_index    <= r_best_idx;
            end else begin
                o_out_value    <= '0;
                o_out_priority <= '0;
                o_out_index    <= '0;
            end
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/apq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apq_ctrl: array priority queue controller
// Decodes each request and sequences the search and shift walks over the
// slot storage, issuing one command word to the datapath per cycle.
// ----------------------------------------------------------------------------
module apq_ctrl
    import apq_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire logic [REQ_W-1:0] i_req_type,
    input  wire t_dp_sts          i_sts,
    output t_dp_cmd               o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SCAN_DRAIN,
        S_DECIDE,
        S_SHIFT,
        S_SHIFT_DRAIN
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_is_pop;
    logic   n_is_pop;

    assign busy = (r_state != S_IDLE);

    // next state and command decode
    always_comb begin
        n_state  = r_state;
        n_is_pop = r_is_pop;
        o_cmd    = '0;
        o_cmd.status = ST_OK;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (i_req_type)
                        REQ_PUSH: begin
                            o_cmd.result = 1'b1;
                            if (i_sts.cnt_full) begin
                                o_cmd.status = ST_FULL;
                            end else begin
                                o_cmd.push = 1'b1;
                            end
                        end
                        REQ_POP, REQ_PEEK: begin
                            n_is_pop = (i_req_type == REQ_POP);
                            if (i_sts.cnt_zero) begin
                                o_cmd.result = 1'b1;
                                o_cmd.status = ST_EMPTY;
                            end else begin
                                o_cmd.scan_init = 1'b1;
                                n_state         = S_SCAN;
                            end
                        end
                        default: begin
                            o_cmd.result = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                o_cmd.rd = 1'b1;
                if (i_sts.addr_last) begin
                    n_state = S_SCAN_DRAIN;
                end
            end
            S_SCAN_DRAIN: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (!r_is_pop || i_sts.best_last) begin
                    o_cmd.result   = 1'b1;
                    o_cmd.ret_best = 1'b1;
                    o_cmd.pop_dec  = r_is_pop;
                    n_state        = S_IDLE;
                end else begin
                    o_cmd.shift_init = 1'b1;
                    n_state          = S_SHIFT;
                end
            end
            S_SHIFT: begin
                o_cmd.rd = 1'b1;
                if (i_sts.addr_last) begin
                    n_state = S_SHIFT_DRAIN;
                end
            end
            S_SHIFT_DRAIN: begin
                o_cmd.result   = 1'b1;
                o_cmd.ret_best = 1'b1;
                o_cmd.pop_dec  = 1'b1;
                n_state        = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_is_pop <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_is_pop <= n_is_pop;
        end
    end

endmodule
`default_nettype wire
